// File: rtl/core/b64crc_pkg.sv
package b64crc_pkg;

  localparam int QueueDepthDefault = 2;

  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [7:0]  DELIM_BYTE   = 8'h2A;  // '*'
  localparam logic [7:0]  NEWLINE_BYTE = 8'h0A;
  localparam logic [7:0]  PAD_BYTE     = 8'h3D;  // '='

  // Group character counts carried in a job.
  localparam logic [2:0] NCH_NONE = 3'd0;
  localparam logic [2:0] NCH_TWO  = 3'd2;
  localparam logic [2:0] NCH_THREE = 3'd3;
  localparam logic [2:0] NCH_FOUR = 3'd4;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       frame_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_done;
  } out_t;

  // Work for the back end produced by one input byte.
  typedef struct packed {
    logic        start;   // emit the opening delimiter
    logic [23:0] grp;     // base64 group, first char in the top six bits
    logic [2:0]  nchars;  // real chars in the group, NCH_NONE for no group
    logic        close;   // emit stop, CRC and newline
  } job_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] v;
    v = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      v = v[15] ? ({v[14:0], 1'b0} ^ CRC_POLY) : {v[14:0], 1'b0};
    end
    return v;
  endfunction

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] e;
    e = {2'b00, v};
    if (v < 6'd26) begin
      return 8'(e + 8'd65);
    end else if (v < 6'd52) begin
      return 8'(e + 8'd71);
    end else if (v < 6'd62) begin
      return 8'(e + 8'd252);
    end else if (v == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

endpackage

// File: rtl/core/b64crc_front.sv
module b64crc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  input  logic              full,
  input  b64crc_pkg::in_t   byte_data,
  output logic              push,
  output b64crc_pkg::job_t  job
);
  import b64crc_pkg::*;

  logic [15:0] pend;
  logic [1:0]  cnt;
  logic        in_frame;

  logic [15:0] pend_next;
  logic [1:0]  cnt_next;
  logic        accept;

  assign accept = byte_valid && !full;

  always_comb begin
    job.start  = !in_frame;
    job.grp    = 24'h0;
    job.nchars = NCH_NONE;
    job.close  = byte_data.frame_last;
    if (cnt >= 2'd2) begin
      job.grp    = {pend, byte_data.payload_byte};
      job.nchars = NCH_FOUR;
      pend_next  = 16'h0;
      cnt_next   = 2'd0;
    end else begin
      pend_next  = {pend[7:0], byte_data.payload_byte};
      cnt_next   = 2'(cnt + 2'd1);
    end
    if (byte_data.frame_last) begin
      // flush a partial group, rest padded
      if (cnt_next == 2'd1) begin
        job.grp    = {pend_next[7:0], 16'h0};
        job.nchars = NCH_TWO;
      end else if (cnt_next == 2'd2) begin
        job.grp    = {pend_next, 8'h00};
        job.nchars = NCH_THREE;
      end
      pend_next = 16'h0;
      cnt_next  = 2'd0;
    end
  end

  // middle bytes that only fill the buffer make no job
  assign push = accept && (job.start || (job.nchars != NCH_NONE) || job.close);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= 16'h0;
      cnt      <= 2'd0;
      in_frame <= 1'b0;
    end else if (accept) begin
      pend     <= pend_next;
      cnt      <= cnt_next;
      in_frame <= !byte_data.frame_last;
    end
  end

endmodule

// File: rtl/core/b64crc_queue.sv
module b64crc_queue #(
  parameter int DEPTH = b64crc_pkg::QueueDepthDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  b64crc_pkg::job_t  wr_job,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output b64crc_pkg::job_t  head
);
  import b64crc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CW'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

endmodule

// File: rtl/core/b64crc_back.sv
module b64crc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              empty,
  input  b64crc_pkg::job_t  head,
  output logic              pop,
  output logic              char_valid,
  input  logic              char_stall,
  output b64crc_pkg::out_t  char_data
);
  import b64crc_pkg::*;

  localparam logic [3:0] ST_START = 4'd0;
  localparam logic [3:0] ST_CH0   = 4'd1;
  localparam logic [3:0] ST_CH1   = 4'd2;
  localparam logic [3:0] ST_CH2   = 4'd3;
  localparam logic [3:0] ST_CH3   = 4'd4;
  localparam logic [3:0] ST_STOP  = 4'd5;
  localparam logic [3:0] ST_CRCH  = 4'd6;
  localparam logic [3:0] ST_CRCL  = 4'd7;
  localparam logic [3:0] ST_NL    = 4'd8;

  logic [3:0]  step;
  logic        mid;     // partway through the head job
  logic [15:0] crc;

  logic [3:0]  first_step;
  logic [3:0]  cur_step;
  logic [3:0]  step_next;
  logic        has_grp;
  logic        is_final;
  logic        advance;
  logic [7:0]  cur_byte;
  logic [1:0]  ch_idx;
  logic [5:0]  sextet;
  logic [15:0] crc_in;

  assign has_grp  = (head.nchars != NCH_NONE);
  assign first_step = head.start ? ST_START : (has_grp ? ST_CH0 : ST_STOP);
  assign cur_step = mid ? step : first_step;
  assign advance  = !empty && (!char_valid || !char_stall);
  assign pop      = advance && is_final;
  assign ch_idx   = 2'(cur_step - ST_CH0);
  assign crc_in   = (cur_step == ST_START) ? 16'h0 : crc;

  always_comb begin
    case (ch_idx)
      2'd0:    sextet = head.grp[23:18];
      2'd1:    sextet = head.grp[17:12];
      2'd2:    sextet = head.grp[11:6];
      default: sextet = head.grp[5:0];
    endcase
  end

  always_comb begin
    is_final  = 1'b0;
    step_next = 4'(cur_step + 4'd1);
    case (cur_step)
      ST_START: begin
        is_final  = !has_grp && !head.close;
        step_next = has_grp ? ST_CH0 : ST_STOP;
      end
      ST_CH3:   is_final = !head.close;
      ST_NL:    is_final = 1'b1;
      default:  is_final = 1'b0;
    endcase
  end

  always_comb begin
    case (cur_step)
      ST_START, ST_STOP: cur_byte = DELIM_BYTE;
      ST_CH0, ST_CH1, ST_CH2, ST_CH3:
        cur_byte = ({1'b0, ch_idx} < head.nchars) ? b64_char(sextet) : PAD_BYTE;
      ST_CRCH:  cur_byte = crc[15:8];
      ST_CRCL:  cur_byte = crc[7:0];
      default:  cur_byte = NEWLINE_BYTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid        <= 1'b0;
      step       <= ST_START;
      char_valid <= 1'b0;
    end else begin
      if (advance) begin
        mid  <= !is_final;
        step <= step_next;
      end
      if (!char_valid || !char_stall) begin
        char_valid <= !empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      char_data.out_byte   <= cur_byte;
      char_data.run_last   <= is_final;
      char_data.frame_done <= (cur_step == ST_NL);
      if (cur_step inside {[ST_START:ST_STOP]}) begin
        crc <= crc16_byte(crc_in, cur_byte);
      end
    end
  end

  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    char_valid && char_data.frame_done |-> char_data.run_last)
    else $error("frame_done without run_last");

  a_mid_has_job: assert property (@(posedge clk) disable iff (rst)
    mid |-> !empty)
    else $error("job in progress but queue empty");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    mid |-> (step <= ST_NL && step != ST_START))
    else $error("step register out of range");

  a_pop_on_advance: assert property (@(posedge clk) disable iff (rst)
    pop |=> char_valid && char_data.run_last)
    else $error("job retired without closing transfer");

endmodule

// File: rtl/core/base64_crc_frame_encoder_unit.sv
// Channel | Dir | Payload              | Handshake
// byte    | in  | payload_byte, last   | byte_valid / byte_stall
// char    | out | out_byte, run/done   | char_valid / char_stall
//
// The back end sends one byte per cycle while jobs are queued and char_stall is
// low; an input byte yields n transfers (0 to 9), so a frame of N payload bytes
// gives 4*ceil(N/3) + 5 bytes at the output. Input is taken in consecutive cycles
// until the job queue (QUEUE_DEPTH entries) fills.
// Reset is synchronous, no clearing pass.
// char_stall holds the output register and, through the queue, byte_stall.
module base64_crc_frame_encoder_unit #(
  parameter int QUEUE_DEPTH = b64crc_pkg::QueueDepthDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_stall,
  input  b64crc_pkg::in_t   byte_data,
  output logic              char_valid,
  input  logic              char_stall,
  output b64crc_pkg::out_t  char_data
);
  import b64crc_pkg::*;

  logic push;
  logic pop;
  logic full;
  logic empty;
  job_t wr_job;
  job_t head;

  // stall tracks queue occupancy only
  assign byte_stall = full;

  // front: buffers bytes into groups, decides what each byte emits
  b64crc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .full       (full),
    .byte_data  (byte_data),
    .push       (push),
    .job        (wr_job)
  );

  b64crc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .full   (full),
    .empty  (empty),
    .head   (head)
  );

  // back: steps through each job, one byte per cycle unless stalled, with a CRC update for delimiters and chars
  b64crc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (empty),
    .head       (head),
    .pop        (pop),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_data  (char_data)
  );

endmodule
